@@ design/magic_length_deframer_macros.svh @@
// Assertion helpers used by the deframer top module.
`ifndef MAGIC_LENGTH_DEFRAMER_MACROS_SVH
`define MAGIC_LENGTH_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MLD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MLD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

@@ design/mld_pkg.sv @@
`timescale 1ns / 1ps

package mld_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FIRST_MAGIC  = 2'd0;
    localparam logic [1:0] CFG_SECOND_MAGIC = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH   = 2'd2;

    // Register reset values.
    localparam logic [7:0]  FIRST_MAGIC_RST  = 8'h94;
    localparam logic [7:0]  SECOND_MAGIC_RST = 8'hC3;
    localparam logic [15:0] MAX_LENGTH_RST   = 16'd256;

    typedef enum logic [2:0] {
        PH_SEEK1   = 3'd0,
        PH_SEEK2   = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0]  first_magic;
        logic [7:0]  second_magic;
        logic [15:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  payload_byte;
        logic        frame_done;
        logic        empty_frame;
        logic [15:0] frame_length;
        logic [31:0] resync_total;
    } result_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] declared_length;
    } status_t;

endpackage

@@ design/magic_length_deframer.sv @@
`timescale 1ns / 1ps

// Length-prefixed byte-stream deframer. Every byte accepted on the s_ channel
// produces exactly one result transfer on the m_ channel. The block hunts for
// the first and then the second magic byte (a repeated first magic byte keeps
// it waiting for the second), reads a big-endian 16-bit payload length, and
// then passes each payload byte out with has_byte set, flagging the last one
// with frame_done. A zero length completes an empty frame on the low length
// byte. A wrong second byte or a length above max_length bumps resync_total
// and restarts the hunt. Throughput is one byte per clock while m_ready is
// high. The result for a byte passes from the input register through the
// parser update into the result register, and low m_ready can hold it in
// either register. Configuration
// registers (index 0 first_magic, 1 second_magic, 2 max_length) are written
// through cfg_wr_en/cfg_index/cfg_wdata and must only be changed while the
// block is idle.
module magic_length_deframer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_has_byte,
    output logic [7:0]  m_payload_byte,
    output logic        m_frame_done,
    output logic        m_empty_frame,
    output logic [15:0] m_frame_length,
    output logic [31:0] m_resync_total
);

`include "magic_length_deframer_macros.svh"

    mld_pkg::cfg_t    cfg_reg;
    mld_pkg::result_t step_result;
    mld_pkg::result_t result_reg;
    mld_pkg::status_t parser_status;

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       out_valid_reg;
    logic       out_advance;
    logic       step_en;

    // The result register can take a new value when it is empty or its
    // current transfer completes this cycle. The input register refills
    // whenever its byte moves on, so a byte can enter every clock.
    assign out_advance = !out_valid_reg || m_ready;
    assign step_en     = in_valid_reg && out_advance;
    assign s_ready     = !in_valid_reg || out_advance;

    // Configuration registers; indexes outside the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_magic  <= mld_pkg::FIRST_MAGIC_RST;
            cfg_reg.second_magic <= mld_pkg::SECOND_MAGIC_RST;
            cfg_reg.max_length   <= mld_pkg::MAX_LENGTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mld_pkg::CFG_FIRST_MAGIC:  cfg_reg.first_magic  <= cfg_wdata[7:0];
                mld_pkg::CFG_SECOND_MAGIC: cfg_reg.second_magic <= cfg_wdata[7:0];
                mld_pkg::CFG_MAX_LENGTH:   cfg_reg.max_length   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
        end
    end

    mld_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .data_byte (in_data_reg),
        .cfg       (cfg_reg),
        .result    (step_result),
        .status    (parser_status)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            result_reg <= step_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_has_byte     = result_reg.has_byte;
    assign m_payload_byte = result_reg.payload_byte;
    assign m_frame_done   = result_reg.frame_done;
    assign m_empty_frame  = result_reg.empty_frame;
    assign m_frame_length = result_reg.frame_length;
    assign m_resync_total = result_reg.resync_total;

    // An empty frame always completes and reports zero length.
    `MLD_ASSERT_IMPLY(a_empty_done, aclk, aresetn, m_valid && m_empty_frame, m_frame_done && (m_frame_length == 16'd0))
    // A payload byte always belongs to a frame of nonzero declared length.
    `MLD_ASSERT_IMPLY(a_payload_len, aclk, aresetn, m_valid && m_has_byte, m_frame_length != 16'd0)
    // A completed frame sends the parser back to the hunt for the first byte.
    `MLD_ASSERT_NEXT(a_done_seek, aclk, aresetn, step_en && step_result.frame_done, parser_status.phase == mld_pkg::PH_SEEK1)
    // While payload is streaming, the stored length is nonzero.
    `MLD_ASSERT_IMPLY(a_payload_state, aclk, aresetn, parser_status.phase == mld_pkg::PH_PAYLOAD, parser_status.declared_length != 16'd0)

endmodule

@@ design/mld_parser.sv @@
`timescale 1ns / 1ps

// Frame parser state machine. One byte is consumed on each cycle with step_en
// high; the result for that byte is presented combinationally on result.
module mld_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_en,
    input  logic [7:0]      data_byte,
    input  mld_pkg::cfg_t   cfg,
    output mld_pkg::result_t result,
    output mld_pkg::status_t status
);

    mld_pkg::phase_t phase_reg, phase_next;
    logic [15:0] declared_length_reg, declared_length_next;
    logic [15:0] received_count_reg, received_count_next;
    logic [31:0] resync_counter_reg, resync_counter_next;

    logic [15:0] full_length;
    logic [15:0] count_inc;

    assign full_length = {declared_length_reg[15:8], data_byte};
    assign count_inc   = received_count_reg + 16'd1;

    // Next-state logic.
    always_comb begin
        phase_next           = phase_reg;
        declared_length_next = declared_length_reg;
        received_count_next  = received_count_reg;
        resync_counter_next  = resync_counter_reg;
        unique case (phase_reg)
            mld_pkg::PH_SEEK2: begin
                if (data_byte == cfg.second_magic) begin
                    phase_next = mld_pkg::PH_LEN_HI;
                end else if (data_byte != cfg.first_magic) begin
                    phase_next          = mld_pkg::PH_SEEK1;
                    resync_counter_next = resync_counter_reg + 32'd1;
                end
            end
            mld_pkg::PH_LEN_HI: begin
                declared_length_next = {data_byte, 8'h00};
                phase_next           = mld_pkg::PH_LEN_LO;
            end
            mld_pkg::PH_LEN_LO: begin
                declared_length_next = full_length;
                if (full_length > cfg.max_length) begin
                    phase_next          = mld_pkg::PH_SEEK1;
                    resync_counter_next = resync_counter_reg + 32'd1;
                end else begin
                    received_count_next = '0;
                    phase_next = (full_length == 16'd0) ? mld_pkg::PH_SEEK1
                                                        : mld_pkg::PH_PAYLOAD;
                end
            end
            mld_pkg::PH_PAYLOAD: begin
                received_count_next = count_inc;
                if (count_inc == declared_length_reg) begin
                    phase_next = mld_pkg::PH_SEEK1;
                end
            end
            default: begin
                phase_next = (data_byte == cfg.first_magic) ? mld_pkg::PH_SEEK2
                                                            : mld_pkg::PH_SEEK1;
            end
        endcase
    end

    // Result logic.
    always_comb begin
        result              = '0;
        result.resync_total = resync_counter_next;
        unique case (phase_reg)
            mld_pkg::PH_LEN_LO: begin
                if (full_length <= cfg.max_length) begin
                    result.frame_length = full_length;
                    if (full_length == 16'd0) begin
                        result.frame_done  = 1'b1;
                        result.empty_frame = 1'b1;
                    end
                end
            end
            mld_pkg::PH_PAYLOAD: begin
                result.has_byte     = 1'b1;
                result.payload_byte = data_byte;
                result.frame_length = declared_length_reg;
                result.frame_done   = (count_inc == declared_length_reg);
            end
            default: begin
                result.frame_length = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= mld_pkg::PH_SEEK1;
            declared_length_reg <= '0;
            received_count_reg  <= '0;
            resync_counter_reg  <= '0;
        end else if (step_en) begin
            phase_reg           <= phase_next;
            declared_length_reg <= declared_length_next;
            received_count_reg  <= received_count_next;
            resync_counter_reg  <= resync_counter_next;
        end
    end

    assign status.phase           = phase_reg;
    assign status.declared_length = declared_length_reg;

endmodule

@@ tb/magic_length_deframer_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels and the register port of the deframer, keeps its own
// copy of the parser state, and checks every result transfer in order.
module magic_length_deframer_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_has_byte,
    input  logic [7:0]  m_payload_byte,
    input  logic        m_frame_done,
    input  logic        m_empty_frame,
    input  logic [15:0] m_frame_length,
    input  logic [31:0] m_resync_total,

    output int          mismatch_count,
    output int          pending_count,
    output int          checked_count,
    output int          frame_count
);

    mld_pkg::cfg_t    regs;
    mld_pkg::phase_t  hunt_phase;
    logic [15:0]      length_field;
    logic [15:0]      bytes_in_frame;
    logic [31:0]      resyncs;
    mld_pkg::result_t expected_results[$];
    int               mismatches;
    int               checked;
    int               frames;

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
        checked_count  = 0;
        frame_count    = 0;
        mismatches     = 0;
        checked        = 0;
        frames         = 0;
    end

    // Advances the parser by one received byte and returns what it reports.
    function automatic mld_pkg::result_t next_deframer_result(input logic [7:0] b);
        mld_pkg::result_t r;
        r = '0;
        case (hunt_phase)
            mld_pkg::PH_SEEK2: begin
                // The second-byte match wins when both magic bytes are equal.
                if (b == regs.second_magic) begin
                    hunt_phase = mld_pkg::PH_LEN_HI;
                end else if (b != regs.first_magic) begin
                    hunt_phase = mld_pkg::PH_SEEK1;
                    resyncs    = resyncs + 32'd1;
                end
            end
            mld_pkg::PH_LEN_HI: begin
                length_field = {b, 8'h00};
                hunt_phase   = mld_pkg::PH_LEN_LO;
            end
            mld_pkg::PH_LEN_LO: begin
                length_field = {length_field[15:8], b};
                if (length_field > regs.max_length) begin
                    hunt_phase = mld_pkg::PH_SEEK1;
                    resyncs    = resyncs + 32'd1;
                end else begin
                    bytes_in_frame = 16'd0;
                    if (length_field == 16'd0) begin
                        hunt_phase    = mld_pkg::PH_SEEK1;
                        r.frame_done  = 1'b1;
                        r.empty_frame = 1'b1;
                    end else begin
                        hunt_phase     = mld_pkg::PH_PAYLOAD;
                        r.frame_length = length_field;
                    end
                end
            end
            mld_pkg::PH_PAYLOAD: begin
                bytes_in_frame = bytes_in_frame + 16'd1;
                r.has_byte     = 1'b1;
                r.payload_byte = b;
                r.frame_length = length_field;
                if (bytes_in_frame == length_field) begin
                    hunt_phase   = mld_pkg::PH_SEEK1;
                    r.frame_done = 1'b1;
                end
            end
            default: begin
                hunt_phase = (b == regs.first_magic) ? mld_pkg::PH_SEEK2
                                                     : mld_pkg::PH_SEEK1;
            end
        endcase
        r.resync_total = resyncs;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        mld_pkg::result_t got;
        mld_pkg::result_t want;
        if (!aresetn) begin
            regs.first_magic  = mld_pkg::FIRST_MAGIC_RST;
            regs.second_magic = mld_pkg::SECOND_MAGIC_RST;
            regs.max_length   = mld_pkg::MAX_LENGTH_RST;
            hunt_phase        = mld_pkg::PH_SEEK1;
            length_field      = 16'd0;
            bytes_in_frame    = 16'd0;
            resyncs           = 32'd0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.has_byte     = m_has_byte;
                got.payload_byte = m_payload_byte;
                got.frame_done   = m_frame_done;
                got.empty_frame  = m_empty_frame;
                got.frame_length = m_frame_length;
                got.resync_total = m_resync_total;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result transfer with nothing outstanding", $realtime);
                        $display("  expected none");
                        $display({"  actual   has=%0d byte=%02h done=%0d empty=%0d",
                                  " len=%0d resync=%0d"},
                                 got.has_byte, got.payload_byte, got.frame_done,
                                 got.empty_frame, got.frame_length, got.resync_total);
                    end
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (got.frame_done === 1'b1)
                        frames++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result %0d differs", $realtime, checked);
                            $display({"  expected has=%0d byte=%02h done=%0d empty=%0d",
                                      " len=%0d resync=%0d"},
                                     want.has_byte, want.payload_byte, want.frame_done,
                                     want.empty_frame, want.frame_length, want.resync_total);
                            $display({"  actual   has=%0d byte=%02h done=%0d empty=%0d",
                                      " len=%0d resync=%0d"},
                                     got.has_byte, got.payload_byte, got.frame_done,
                                     got.empty_frame, got.frame_length, got.resync_total);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(next_deframer_result(s_data_byte));
            if (cfg_wr_en) begin
                case (cfg_index)
                    mld_pkg::CFG_FIRST_MAGIC:  regs.first_magic  = cfg_wdata[7:0];
                    mld_pkg::CFG_SECOND_MAGIC: regs.second_magic = cfg_wdata[7:0];
                    mld_pkg::CFG_MAX_LENGTH:   regs.max_length   = cfg_wdata;
                    default: ;
                endcase
            end
        end
        mismatch_count <= mismatches;
        pending_count  <= expected_results.size();
        checked_count  <= checked;
        frame_count    <= frames;
    end

endmodule

@@ tb/tb_magic_length_deframer.sv @@
`timescale 1ns / 1ps

// Top of the deframer testbench. It only makes stimulus and gives the verdict;
// prediction and comparison live in the checker instantiated beside the block.
module tb_magic_length_deframer;

    // Register index that maps to no register; writes to it must be dropped.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // Random bytes per register setting, not counting bytes the hunt ignores.
    localparam int BYTES_PER_SETTING = 330;

    // Generous cycle limit for the whole run.
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_has_byte;
    logic [7:0]  m_payload_byte;
    logic        m_frame_done;
    logic        m_empty_frame;
    logic [15:0] m_frame_length;
    logic [31:0] m_resync_total;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int frame_count;

    // The settings the stimulus currently builds frames for.
    logic [7:0]  cur_first;
    logic [7:0]  cur_second;
    logic [15:0] cur_max;

    // When a side is calm it inserts no idle cycles at all, which gives long
    // stretches of back-to-back transfers between the bursty ones.
    bit sender_calm;
    bit receiver_calm;

    int bytes_sent;
    int ignored_bytes;
    int settings_used;
    int cycle_count;

    magic_length_deframer u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_has_byte     (m_has_byte),
        .m_payload_byte (m_payload_byte),
        .m_frame_done   (m_frame_done),
        .m_empty_frame  (m_empty_frame),
        .m_frame_length (m_frame_length),
        .m_resync_total (m_resync_total)
    );

    magic_length_deframer_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_has_byte     (m_has_byte),
        .m_payload_byte (m_payload_byte),
        .m_frame_done   (m_frame_done),
        .m_empty_frame  (m_empty_frame),
        .m_frame_length (m_frame_length),
        .m_resync_total (m_resync_total),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count),
        .frame_count    (frame_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog. A hung handshake or a lost result ends the run here.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_count);
            $display("status: fail");
            $finish;
        end
    end

    // Result side. Before each transfer the receiver holds ready low for a
    // random number of cycles, then keeps it high until the transfer happens.
    // Ready is only lowered when a stall was actually drawn, so a run of
    // zero stalls keeps it high without any glitch within a time step.
    initial begin : result_sink
        int stall;
        m_ready       = 1'b0;
        receiver_calm = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 49) == 0)
                receiver_calm = !receiver_calm;
            stall = receiver_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Offers one byte on the input channel and returns right after the edge
    // at which it was transferred. Valid is left high so that the next byte
    // can follow without a gap; it is only dropped when a gap is drawn.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // A complete frame with the current magic bytes. The payload is only sent
    // when the block will take the length; a rejected length makes the block
    // hunt again, so the stream carries on with whatever comes next.
    task automatic send_frame(input logic [15:0] len);
        push_byte(cur_first);
        push_byte(cur_second);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
        if (len != 16'd0 && len <= cur_max) begin
            for (int i = 0; i < len; i++)
                push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly short frames, some empty ones, a few long ones, and lengths
    // above the current maximum whenever such a length exists.
    function automatic logic [15:0] pick_length(input logic [15:0] mx);
        int roll;
        int cap;
        roll = $urandom_range(0, 99);
        if (mx != 16'hFFFF && roll < 15)
            return 16'($urandom_range(int'(mx) + 1, 65535));
        if (roll < 27 || mx == 16'd0)
            return 16'd0;
        cap = (roll < 30) ? 300 : 24;
        if (int'(mx) < cap)
            cap = int'(mx);
        return 16'($urandom_range(1, cap));
    endfunction

    // Waits until every result has come back and lets the two-stage pipeline
    // settle, so the registers can be changed safely.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all three registers on consecutive edges, followed by a write
    // to the unmapped index that the block has to ignore. The magic bytes
    // carry junk in the upper half of the write data.
    task automatic apply_settings(input logic [7:0] f, input logic [7:0] s,
                                  input logic [15:0] mx);
        cfg_wr_en <= 1'b1;
        cfg_index <= mld_pkg::CFG_FIRST_MAGIC;
        cfg_wdata <= {8'($urandom_range(0, 255)), f};
        @(posedge aclk);
        cfg_index <= mld_pkg::CFG_SECOND_MAGIC;
        cfg_wdata <= {8'($urandom_range(0, 255)), s};
        @(posedge aclk);
        cfg_index <= mld_pkg::CFG_MAX_LENGTH;
        cfg_wdata <= mx;
        @(posedge aclk);
        cfg_index <= CFG_SPARE;
        cfg_wdata <= 16'($urandom_range(0, 65535));
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        cur_first  = f;
        cur_second = s;
        cur_max    = mx;
        settings_used++;
    endtask

    // Random traffic for one register setting. Most of it is well-formed
    // frames with random lengths and content; the rest is line noise, wrong
    // second bytes, repeated first bytes and headers cut short.
    task automatic run_random(input int quota);
        int start;
        int mark;
        int roll;
        int reps;
        logic [7:0] b;
        start = bytes_sent - ignored_bytes;
        // A frame of exactly the maximum length, and one just above it.
        if (cur_max <= 16'd300)
            send_frame(cur_max);
        if (cur_max != 16'hFFFF)
            send_frame(cur_max + 16'd1);
        while (bytes_sent - ignored_bytes - start < quota) begin
            if ($urandom_range(0, 19) == 0)
                sender_calm = !sender_calm;
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                send_frame(pick_length(cur_max));
            end else if (roll < 78) begin
                // Noise between frames; the hunt mostly skips it.
                mark = bytes_sent;
                reps = $urandom_range(1, 4);
                repeat (reps) push_byte(8'($urandom_range(0, 255)));
                ignored_bytes += bytes_sent - mark;
            end else if (roll < 86) begin
                // A second byte that matches neither magic byte.
                do b = 8'($urandom_range(0, 255));
                while (b == cur_first || b == cur_second);
                push_byte(cur_first);
                push_byte(b);
            end else if (roll < 92) begin
                // Extra copies of the first magic byte ahead of a frame.
                reps = $urandom_range(1, 3);
                repeat (reps) push_byte(cur_first);
                send_frame(pick_length(cur_max));
            end else begin
                // A header cut off after its high length byte; the next
                // frame's first byte then serves as the low length byte.
                // With the largest maximum every length is taken, so the
                // high byte stays zero to keep the swallowed payload short.
                push_byte(cur_first);
                push_byte(cur_second);
                if (cur_max == 16'hFFFF)
                    push_byte(8'h00);
                else
                    push_byte(8'($urandom_range(0, 255)));
                send_frame(pick_length(cur_max));
            end
        end
    endtask

    initial begin : stimulus
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = mld_pkg::CFG_FIRST_MAGIC;
        cfg_wdata     = 16'd0;
        s_valid       = 1'b0;
        s_data_byte   = 8'd0;
        sender_calm   = 1'b0;
        bytes_sent    = 0;
        ignored_bytes = 0;
        settings_used = 1;
        cur_first     = mld_pkg::FIRST_MAGIC_RST;
        cur_second    = mld_pkg::SECOND_MAGIC_RST;
        cur_max       = mld_pkg::MAX_LENGTH_RST;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, with the reset settings. Noise at both extremes
        // while hunting must be skipped without a resync.
        push_byte(8'h00);
        push_byte(8'hFF);
        // A repeated first magic byte keeps the wait, then an empty frame.
        push_byte(mld_pkg::FIRST_MAGIC_RST);
        push_byte(mld_pkg::FIRST_MAGIC_RST);
        push_byte(mld_pkg::SECOND_MAGIC_RST);
        push_byte(8'h00);
        push_byte(8'h00);
        // A wrong second byte counts a resync.
        push_byte(mld_pkg::FIRST_MAGIC_RST);
        push_byte(8'h55);
        // Length one above the maximum is rejected with a resync.
        push_byte(mld_pkg::FIRST_MAGIC_RST);
        push_byte(mld_pkg::SECOND_MAGIC_RST);
        push_byte(8'h01);
        push_byte(8'h01);
        // A huge declared length is rejected too.
        push_byte(mld_pkg::FIRST_MAGIC_RST);
        push_byte(mld_pkg::SECOND_MAGIC_RST);
        push_byte(8'hFF);
        push_byte(8'hFF);
        // A three-byte frame with payload bytes at both extremes.
        push_byte(mld_pkg::FIRST_MAGIC_RST);
        push_byte(mld_pkg::SECOND_MAGIC_RST);
        push_byte(8'h00);
        push_byte(8'h03);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hA5);

        run_random(BYTES_PER_SETTING);
        wait_drained();

        // Magic bytes at the extremes, and a maximum of zero so that only
        // empty frames pass.
        apply_settings(8'h00, 8'hFF, 16'd0);
        run_random(BYTES_PER_SETTING);
        wait_drained();

        // Equal magic bytes: the second copy already advances to the length.
        // The largest maximum means no length is ever rejected.
        apply_settings(8'h5A, 8'h5A, 16'hFFFF);
        run_random(BYTES_PER_SETTING);
        wait_drained();

        // Swapped extremes, and a maximum of one so that frames carry at most one byte.
        apply_settings(8'hFF, 8'h00, 16'd1);
        run_random(BYTES_PER_SETTING);
        wait_drained();

        // Random magic bytes and a small random maximum.
        apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       16'($urandom_range(2, 60)));
        run_random(BYTES_PER_SETTING);
        wait_drained();

        // Let the pipeline empty out completely before the verdict.
        repeat (8) @(posedge aclk);

        $display("Covered %0d input bytes under %0d register settings.",
                 bytes_sent, settings_used);
        $display("Checked %0d results, %0d completed frames, %0d mismatches, %0d left over.",
                 checked_count, frame_count, mismatch_count, pending_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
